// File: sv/tla_pkg.sv
`timescale 1ns / 1ps

package tla_pkg;

  typedef enum logic [1:0] {
    MODE_WRITE = 2'd0,
    MODE_READ  = 2'd1,
    MODE_CLEAR = 2'd2,
    MODE_STEP  = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CELL,
    ST_GEN
  } state_t;

  localparam logic [3:0] BIRTH_COUNT = 4'd3;
  localparam logic [3:0] SURVIVE_LOW = 4'd2;

endpackage

// File: sv/tla_row_next.sv
`timescale 1ns / 1ps

module tla_row_next #(
  parameter int MAX_SIDE = 64
) (
  input  logic [MAX_SIDE-1:0]              up,
  input  logic [MAX_SIDE-1:0]              cur,
  input  logic [MAX_SIDE-1:0]              dn,
  input  logic [$clog2(MAX_SIDE+1)-1:0]    side,
  output logic [MAX_SIDE-1:0]              row_next,
  output logic                             changed
);
  import tla_pkg::*;

  localparam int AW = $clog2(MAX_SIDE);
  localparam int SW = $clog2(MAX_SIDE + 1);

  always_comb begin
    logic [AW-1:0] li;
    logic          lu, lc, ld, ru, rc, rd;
    logic          last;
    logic [3:0]    n;
    logic          nv;
    int            prv;
    int            nxt;
    li       = AW'(side - SW'(1));
    row_next = cur;
    changed  = 1'b0;
    for (int x = 0; x < MAX_SIDE; x++) begin
      prv  = (x == 0) ? MAX_SIDE - 1 : x - 1;
      nxt  = (x == MAX_SIDE - 1) ? 0 : x + 1;
      last = (x == int'(side) - 1);
      lu   = (x == 0) ? up[li]  : up[prv];
      lc   = (x == 0) ? cur[li] : cur[prv];
      ld   = (x == 0) ? dn[li]  : dn[prv];
      ru   = last ? up[0]  : up[nxt];
      rc   = last ? cur[0] : cur[nxt];
      rd   = last ? dn[0]  : dn[nxt];
      n    = 4'(lu) + 4'(up[x]) + 4'(ru) + 4'(lc) + 4'(rc)
           + 4'(ld) + 4'(dn[x]) + 4'(rd);
      if (cur[x]) begin
        nv = (n >= SURVIVE_LOW) && (n <= BIRTH_COUNT);
      end else begin
        nv = (n == BIRTH_COUNT);
      end
      if (x < int'(side)) begin
        row_next[x] = nv;
        changed     = changed | (nv ^ cur[x]);
      end
    end
  end

endmodule

// File: sv/toroidal_life_automaton.sv
`timescale 1ns / 1ps
// Toroidal life field, MAX_SIDE by MAX_SIDE cells, held one row per memory word.
// Command channel: a transaction is taken when start is high and busy is low;
// mode, cell_x, cell_y, cell_value and generation_count are sampled then.
// Result channel: done pulses high for one cycle with cell_read, stable and
// generations_run; the receiver cannot stall, so nothing waits on it.
// Configuration: field_size is written when field_size_wr is high; only
// write it while busy is low. It sets the wrap side and clears stable.
// Flow: write and read cell pass through the cell state before done; a step
// that runs no generation gives done straight from idle; clear writes one row
// per cycle over all MAX_SIDE rows. In each generation of a step, one memory
// read per row feeds a three-row window, each new row is computed across all
// columns at once and written back, plus the pipeline drain and the wrap row.
// One transaction is worked at a time; busy stays high until its done, but a
// step that runs no generation never raises busy. Reset: synchronous; after
// rst falls the block sweeps every memory row to dead cells with busy high before the first start is taken.
module toroidal_life_automaton #(
  parameter int MAX_SIDE = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  mode,
  input  logic [5:0]  cell_x,
  input  logic [5:0]  cell_y,
  input  logic        cell_value,
  input  logic [15:0] generation_count,
  input  logic        field_size_wr,
  input  logic [6:0]  field_size,
  output logic        done,
  output logic        cell_read,
  output logic        stable,
  output logic [15:0] generations_run
);
  import tla_pkg::*;

  localparam int AW = $clog2(MAX_SIDE);
  localparam int SW = $clog2(MAX_SIDE + 1);

  function automatic logic [SW-1:0] clamp_side(input logic [6:0] fs);
    if (fs == 7'd0) begin
      return SW'(1);
    end else if (int'(fs) > MAX_SIDE) begin
      return SW'(MAX_SIDE);
    end else begin
      return SW'(fs);
    end
  endfunction

  state_t state, state_next;

  logic [MAX_SIDE-1:0] mem [MAX_SIDE];
  logic [MAX_SIDE-1:0] rdata;
  logic                mem_we;
  logic [AW-1:0]       mem_wa;
  logic [AW-1:0]       mem_ra;
  logic [MAX_SIDE-1:0] mem_wd;
  logic [MAX_SIDE-1:0] cell_wd;

  logic [SW-1:0]       side;
  logic                stable_flag;
  logic [AW-1:0]       clr_cnt;
  logic                clr_reply;

  mode_t               mode_q;
  logic [AW-1:0]       cx_q;
  logic [AW-1:0]       cy_q;
  logic                cv_q;
  logic [15:0]         count_q;
  logic                in_field_q;
  logic [15:0]         run;

  logic [SW-1:0]       rc;
  logic                rd_done;
  logic                p1;
  logic                p2;
  logic                fin;
  logic [SW-1:0]       j1;
  logic [SW-1:0]       j2;
  logic                chg_acc;
  logic [MAX_SIDE-1:0] win_up;
  logic [MAX_SIDE-1:0] win_cur;
  logic [MAX_SIDE-1:0] win_dn;
  logic [MAX_SIDE-1:0] row0_save;

  logic [MAX_SIDE-1:0] row_next;
  logic                row_chg;
  logic                changed_all;
  logic                gen_stop;
  logic                in_field;
  logic                clr_last;

  tla_row_next #(
    .MAX_SIDE(MAX_SIDE)
  ) u_row (
    .up      (win_up),
    .cur     (win_cur),
    .dn      (win_dn),
    .side    (side),
    .row_next(row_next),
    .changed (row_chg)
  );

  assign busy            = (state != ST_IDLE);
  assign stable          = stable_flag;
  assign generations_run = run;
  assign changed_all     = chg_acc | row_chg;
  assign gen_stop        = !changed_all || ((run + 16'd1) == count_q);
  assign in_field        = (32'(cell_x) < 32'(side)) && (32'(cell_y) < 32'(side));
  assign clr_last        = (clr_cnt == AW'(MAX_SIDE - 1));

  always_comb begin
    cell_wd         = rdata;
    cell_wd[cx_q]   = cv_q;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rdata <= mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    mem_we     = 1'b0;
    mem_wa     = clr_cnt;
    mem_wd     = '0;
    mem_ra     = AW'(cell_y);
    unique case (state)
      ST_CLEAR: begin
        mem_we = 1'b1;
        if (clr_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          unique case (mode_t'(mode))
            MODE_WRITE, MODE_READ: state_next = ST_CELL;
            MODE_CLEAR:            state_next = ST_CLEAR;
            MODE_STEP: begin
              if (stable_flag || (generation_count == 16'd0)) begin
                state_next = ST_IDLE;
              end else begin
                state_next = ST_GEN;
              end
            end
          endcase
        end
      end
      ST_CELL: begin
        mem_we     = (mode_q == MODE_WRITE) && in_field_q;
        mem_wa     = cy_q;
        mem_wd     = cell_wd;
        state_next = ST_IDLE;
      end
      ST_GEN: begin
        mem_ra = (rc == '0) ? AW'(side - SW'(1)) : AW'(rc - SW'(1));
        mem_wd = row_next;
        if (p2 && (j2 >= SW'(2))) begin
          mem_we = 1'b1;
          mem_wa = AW'(j2 - SW'(2));
        end
        if (fin) begin
          mem_we = 1'b1;
          mem_wa = AW'(side - SW'(1));
          if (gen_stop) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done        <= 1'b0;
      stable_flag <= 1'b0;
      side        <= clamp_side(7'd64);
      clr_cnt     <= '0;
      clr_reply   <= 1'b0;
      rc          <= '0;
      rd_done     <= 1'b0;
      p1          <= 1'b0;
      p2          <= 1'b0;
      fin         <= 1'b0;
      chg_acc     <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_CLEAR: begin
          if (clr_last) begin
            clr_cnt   <= '0;
            clr_reply <= 1'b0;
            done      <= clr_reply;
          end else begin
            clr_cnt <= clr_cnt + AW'(1);
          end
        end
        ST_IDLE: begin
          if (start) begin
            rc      <= '0;
            rd_done <= 1'b0;
            p1      <= 1'b0;
            p2      <= 1'b0;
            fin     <= 1'b0;
            chg_acc <= 1'b0;
            unique case (mode_t'(mode))
              MODE_WRITE, MODE_READ: ;
              MODE_CLEAR: begin
                stable_flag <= 1'b0;
                clr_reply   <= 1'b1;
              end
              MODE_STEP: begin
                if (stable_flag || (generation_count == 16'd0)) begin
                  done <= 1'b1;
                end
              end
            endcase
          end
        end
        ST_CELL: begin
          done <= 1'b1;
          if (in_field_q && (mode_q == MODE_WRITE)) begin
            stable_flag <= 1'b0;
          end
        end
        ST_GEN: begin
          p1  <= !rd_done;
          p2  <= p1;
          fin <= p2 && (j2 == side);
          if (!rd_done) begin
            rc <= rc + SW'(1);
            if (rc == side) begin
              rd_done <= 1'b1;
            end
          end
          if (p2 && (j2 >= SW'(2))) begin
            chg_acc <= chg_acc | row_chg;
          end
          if (fin) begin
            if (!changed_all) begin
              stable_flag <= 1'b1;
            end
            if (gen_stop) begin
              done <= 1'b1;
            end else begin
              rc      <= '0;
              rd_done <= 1'b0;
              chg_acc <= 1'b0;
            end
          end
        end
        default: ;
      endcase
      if (field_size_wr) begin
        side        <= clamp_side(field_size);
        stable_flag <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          mode_q     <= mode_t'(mode);
          cx_q       <= AW'(cell_x);
          cy_q       <= AW'(cell_y);
          cv_q       <= cell_value;
          count_q    <= generation_count;
          in_field_q <= in_field;
          cell_read  <= 1'b0;
          run        <= 16'd0;
        end
      end
      ST_CELL: begin
        if (in_field_q && (mode_q == MODE_READ)) begin
          cell_read <= rdata[cx_q];
        end
      end
      ST_GEN: begin
        if (!rd_done) begin
          j1 <= rc;
        end
        if (p1) begin
          win_up  <= win_cur;
          win_cur <= win_dn;
          win_dn  <= rdata;
          j2      <= j1;
          if (j1 == SW'(1)) begin
            row0_save <= rdata;
          end
        end
        if (p2 && (j2 == side)) begin
          win_up  <= win_cur;
          win_cur <= win_dn;
          win_dn  <= row0_save;
        end
        if (fin) begin
          run <= run + 16'd1;
        end
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !mem_we)
    else $error("memory written while idle");

  a_fin_drained: assert property (@(posedge clk) disable iff (rst)
    fin |-> (!p1 && !p2 && rd_done))
    else $error("wrap row computed before window drained");

  a_last_row_read: assert property (@(posedge clk) disable iff (rst)
    (state == ST_GEN && p2 && j2 == side) |-> rd_done)
    else $error("window complete while reads still issuing");

  a_done_cause: assert property (@(posedge clk) disable iff (rst)
    done |-> (($past(start) && !$past(busy)) || ($past(state) != ST_IDLE)))
    else $error("result without a transaction");

  a_run_bound: assert property (@(posedge clk) disable iff (rst)
    done |-> (run <= count_q))
    else $error("more generations run than requested");
`endif

endmodule
